// ===== rtl/sine_tone_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Sine tone generator assertion macros
// Clocked property wrappers shared by the port checker.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_GENERATOR_ASSERT_SVH
`define SINE_TONE_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define STG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define STG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator package
// Register indexes, amplitudes and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [31:0] PHASE_STEP_RST    = 32'd21424600;
    localparam logic        WIDE_SAMPLES_RST  = 1'b1;
    localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd2;

    localparam logic [14:0] WIDE_AMP   = 15'd32767;
    localparam logic [14:0] NARROW_AMP = 15'd127;

    // pi/2 in unsigned Q2.62, truncated
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // (a*b) >> 62, kept to 64 bits
    function automatic logic [63:0] f_mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // truncating unsigned quotient by shift and subtract, den below 2^63
    function automatic logic [63:0] f_udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stg_in_if.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator frame tick channel
// One transaction requests one PCM frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface stg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/stg_out_if.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator sample channel
// One transaction carries one channel sample of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface stg_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] sample;
    logic [2:0]        channel;
    logic              last;

    modport source (output valid, output sample, output channel, output last, input ready);
    modport sink   (input valid, input sample, input channel, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/stg_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator configuration write channel
// One transaction writes one register by index.
// ----------------------------------------------------------------------------
`default_nettype none

interface stg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [stg_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sine_tone_generator.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator
// Phase-accumulator oscillator with a quarter-wave sine table; one frame per
// tick, the same sample repeated on every channel.
// ----------------------------------------------------------------------------
// Each accepted tick (optionally zeroing the phase first) looks up the sine of
// the current phase in a quarter-wave table, mirrors it into the right
// quadrant, and advances the phase by phase_step. The lookup is done in the
// accept cycle and the frame lands in a one-deep frame buffer; the output
// register then sends one channel sample per cycle while the sink is ready.
// The output stage sets the sustained rate: a frame holds the output until
// its last channel sample is taken, and single-channel frames go out one
// per cycle while the sink is ready. The first sample of a frame moves from
// the frame buffer into the output register once the previous frame is done.
// Ticks keep being accepted while the previous frame is still being sent. The sine
// tables are constants built at elaboration; there is no clearing pass after
// reset. Configuration writes are always accepted and should be made while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_tone_generator #(
    parameter int MAX_CHANNELS    = 8,
    parameter int QUARTER_ENTRIES = 256,
    parameter int PHASE_BITS      = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    stg_cfg_if.sink      i_cfg,
    stg_in_if.sink       i_in,
    stg_out_if.source    o_out
);

    localparam int FRAC_BITS = PHASE_BITS - 2;
    localparam int IDX_W     = $clog2(QUARTER_ENTRIES);
    localparam int PROD_W    = FRAC_BITS + IDX_W + 1;
    localparam int CNT_W     = $clog2(MAX_CHANNELS + 1);
    localparam logic [63:0] Q_STEP = stg_pkg::HALF_PI_Q62 / QUARTER_ENTRIES;
    localparam logic [63:0] Q_REM  = stg_pkg::HALF_PI_Q62 % QUARTER_ENTRIES;

    typedef logic [QUARTER_ENTRIES-1:0][14:0] t_wide_rom;
    typedef logic [QUARTER_ENTRIES-1:0][6:0]  t_narrow_rom;

    // sin(pi*k/(2Q)) in Q2.62, Taylor series with truncating steps
    function automatic logic [63:0] f_quarter_sine(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] n;
        x    = Q_STEP * k + stg_pkg::f_udiv64(Q_REM * k, 64'(QUARTER_ENTRIES));
        sum  = x;
        term = x;
        for (n = 64'd1; n <= 64'd40 && term != 64'd0; n = n + 64'd1) begin
            term = stg_pkg::f_udiv64(stg_pkg::f_mul_q62(term, x), 64'd2 * n);
            term = stg_pkg::f_udiv64(stg_pkg::f_mul_q62(term, x), 64'd2 * n + 64'd1);
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic t_wide_rom f_build_wide();
        t_wide_rom   rom;
        logic [63:0] v;
        for (int k = 0; k < QUARTER_ENTRIES; k++) begin
            v = stg_pkg::f_mul_q62(64'(stg_pkg::WIDE_AMP), f_quarter_sine(64'(k)));
            rom[k] = v[14:0];
        end
        return rom;
    endfunction

    function automatic t_narrow_rom f_build_narrow();
        t_narrow_rom rom;
        logic [63:0] v;
        for (int k = 0; k < QUARTER_ENTRIES; k++) begin
            v = stg_pkg::f_mul_q62(64'(stg_pkg::NARROW_AMP), f_quarter_sine(64'(k)));
            rom[k] = v[6:0];
        end
        return rom;
    endfunction

    localparam t_wide_rom   WIDE_ROM   = f_build_wide();
    localparam t_narrow_rom NARROW_ROM = f_build_narrow();

    // configuration
    logic [31:0] r_phase_step;
    logic        r_wide_samples;
    logic [3:0]  r_channel_count;

    // phase accumulator and frame buffer
    logic [PHASE_BITS-1:0] r_phase;
    logic                  r_pend_valid;
    logic signed [15:0]    r_pend_sample;
    logic [CNT_W-1:0]      r_pend_top;

    // output register
    logic                  r_out_valid;
    logic signed [15:0]    r_out_sample;
    logic [CNT_W-1:0]      r_chan;
    logic [CNT_W-1:0]      r_top;

    logic                  in_fire;
    logic                  out_fire;
    logic                  out_last;
    logic                  emit_free;
    logic                  pend_take;

    logic [PHASE_BITS-1:0] base_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [1:0]            quad;
    logic [PROD_W-1:0]     prod;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W:0]        ridx;
    logic [IDX_W-1:0]      addr;
    logic [14:0]           mag;
    logic [15:0]           mag_ext;
    logic signed [15:0]    n_sample;
    logic [CNT_W-1:0]      n_top;

    assign i_cfg.ready = 1'b1;

    assign out_last  = (r_chan == r_top);
    assign out_fire  = r_out_valid && o_out.ready;
    assign emit_free = !r_out_valid || (out_fire && out_last);
    assign pend_take = r_pend_valid && emit_free;
    assign i_in.ready = !r_pend_valid || emit_free;
    assign in_fire   = i_in.valid && i_in.ready;

    // phase to sample
    always_comb begin
        base_phase = i_in.restart ? '0 : r_phase;
        n_phase    = base_phase + PHASE_BITS'(r_phase_step);
        quad       = base_phase[PHASE_BITS-1 -: 2];
        prod       = PROD_W'(base_phase[FRAC_BITS-1:0]) * PROD_W'(QUARTER_ENTRIES);
        idx        = prod[FRAC_BITS +: IDX_W];
        ridx       = (IDX_W+1)'(QUARTER_ENTRIES) - {1'b0, idx};
        addr       = quad[0] ? ridx[IDX_W-1:0] : idx;
        if (quad[0] && idx == '0) begin
            // mirrored index lands on the peak, one past the table
            mag = r_wide_samples ? stg_pkg::WIDE_AMP : stg_pkg::NARROW_AMP;
        end else if (r_wide_samples) begin
            mag = WIDE_ROM[addr];
        end else begin
            mag = {8'd0, NARROW_ROM[addr]};
        end
        mag_ext  = {1'b0, mag};
        n_sample = quad[1] ? -mag_ext : mag_ext;
    end

    // channel count clamped to 1..MAX_CHANNELS, stored as index of last channel
    always_comb begin
        if (r_channel_count == 4'd0) begin
            n_top = '0;
        end else if (32'(r_channel_count) > MAX_CHANNELS) begin
            n_top = CNT_W'(MAX_CHANNELS - 1);
        end else begin
            n_top = CNT_W'(r_channel_count - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step    <= stg_pkg::PHASE_STEP_RST;
            r_wide_samples  <= stg_pkg::WIDE_SAMPLES_RST;
            r_channel_count <= stg_pkg::CHANNEL_COUNT_RST;
            r_phase         <= '0;
            r_pend_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
            r_chan          <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    stg_pkg::REG_PHASE_STEP:    r_phase_step    <= i_cfg.data;
                    stg_pkg::REG_WIDE_SAMPLES:  r_wide_samples  <= i_cfg.data[0];
                    stg_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[3:0];
                    default: ;
                endcase
            end

            if (in_fire) begin
                r_phase      <= n_phase;
                r_pend_valid <= 1'b1;
            end else if (pend_take) begin
                r_pend_valid <= 1'b0;
            end

            if (emit_free) begin
                r_out_valid <= r_pend_valid;
                r_chan      <= '0;
            end else if (out_fire) begin
                r_chan <= r_chan + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pend_sample <= n_sample;
            r_pend_top    <= n_top;
        end
        if (emit_free) begin
            r_out_sample <= r_pend_sample;
            r_top        <= r_pend_top;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.sample  = r_out_sample;
    assign o_out.channel = 3'(r_chan);
    assign o_out.last    = out_last;

endmodule

`default_nettype wire

// ===== rtl/stg_checker.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator port checker
// Frame sequencing and output handshake checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sine_tone_generator_assert.svh"

module stg_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire signed [15:0] i_out_sample,
    input wire [2:0]        i_out_channel,
    input wire              i_out_last
);

    logic out_fire;

    assign out_fire = i_out_valid && i_out_ready;

    // a stalled sample holds
    `STG_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sample) && $stable(i_out_channel) && $stable(i_out_last), "output changed while stalled")

    // channels of a frame follow back to back with the same sample
    `STG_ASSERT_NEXT(a_frame_cont, out_fire && !i_out_last, i_out_valid && $stable(i_out_sample), "frame broken or sample changed within frame")

    `STG_ASSERT_NEXT(a_chan_step, out_fire && !i_out_last, i_out_channel == 3'($past(i_out_channel) + 3'd1), "channel index did not advance")

    // a new frame starts on channel zero
    `STG_ASSERT_NEXT(a_chan_start, out_fire && i_out_last, !i_out_valid || i_out_channel == 3'd0, "frame did not start at channel zero")

endmodule

bind sine_tone_generator stg_checker u_stg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_sample  (o_out.sample),
    .i_out_channel (o_out.channel),
    .i_out_last    (o_out.last)
);

`default_nettype wire
